@@ design/ruf_pkg.sv @@
// Shared types and constants of the rollback union-find block.
// Item structs, command and error codes, memory port structs.
// No dependencies.
`default_nettype none

package ruf_pkg;

   // Sizes of the node store and the undo stack
   localparam int MAX_NODES = 1024;
   localparam int NODE_W    = 10;
   localparam int ENTRY_W   = 11;
   localparam int DEPTH_W   = 11;
   localparam int COUNT_W   = 11;
   localparam int STACK_CAP = 2 * MAX_NODES;

   // Command codes
   localparam logic [1:0] CMD_JOIN     = 2'd0;
   localparam logic [1:0] CMD_ROLLBACK = 2'd1;
   localparam logic [1:0] CMD_QUERY    = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_OK     = 2'd0;
   localparam logic [1:0] ERR_NODE   = 2'd1;
   localparam logic [1:0] ERR_TARGET = 2'd2;

   // Input item
   typedef struct packed {
      logic [1:0]         command;
      logic [NODE_W-1:0]  node_a;
      logic [NODE_W-1:0]  node_b;
      logic [DEPTH_W-1:0] target_depth;
   } req_type;

   // Result item
   typedef struct packed {
      logic               joined;
      logic [NODE_W-1:0]  root;
      logic [COUNT_W-1:0] set_size;
      logic [DEPTH_W-1:0] undo_depth;
      logic [COUNT_W-1:0] components;
      logic [1:0]         error;
   } rsp_type;

   // One undo stack entry: node and its old parent-or-size word
   typedef struct packed {
      logic [NODE_W-1:0]  node;
      logic [ENTRY_W-1:0] old;
   } undo_entry_type;

   // Parent memory ports
   typedef struct packed {
      logic               en;
      logic [NODE_W-1:0]  addr;
      logic [ENTRY_W-1:0] data;
   } par_wr_type;

   typedef struct packed {
      logic              en;
      logic [NODE_W-1:0] addr;
   } par_rd_type;

   // Undo memory ports
   typedef struct packed {
      logic               en;
      logic [DEPTH_W-1:0] addr;
      undo_entry_type     data;
   } undo_wr_type;

   typedef struct packed {
      logic               en;
      logic [DEPTH_W-1:0] addr;
   } undo_rd_type;

endpackage

`default_nettype wire

@@ design/ruf_parent_ram.sv @@
// Parent-or-size store: one write port, one read port, registered read data.
// Uses ruf_pkg port structs.
`default_nettype none

module ruf_parent_ram (
   input  wire logic                          clock,
   input  wire ruf_pkg::par_wr_type           wr,
   input  wire ruf_pkg::par_rd_type           rd,
   output logic [ruf_pkg::ENTRY_W-1:0]        rd_data
);

   logic [ruf_pkg::ENTRY_W-1:0] parent_mem_ff [0:ruf_pkg::MAX_NODES-1];
   logic [ruf_pkg::ENTRY_W-1:0] rd_data_ff;

   // Write, and registered read (old data on collision)
   always_ff @(posedge clock) begin
      if (wr.en) begin
         parent_mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= parent_mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/ruf_undo_ram.sv @@
// Undo stack store: one write port, one read port, registered read data.
// Uses ruf_pkg port structs and the undo entry type.
`default_nettype none

module ruf_undo_ram (
   input  wire logic                    clock,
   input  wire ruf_pkg::undo_wr_type    wr,
   input  wire ruf_pkg::undo_rd_type    rd,
   output ruf_pkg::undo_entry_type      rd_data
);

   ruf_pkg::undo_entry_type undo_mem_ff [0:ruf_pkg::STACK_CAP-1];
   ruf_pkg::undo_entry_type rd_data_ff;

   // Push and pop accesses, one each per cycle at most
   always_ff @(posedge clock) begin
      if (wr.en) begin
         undo_mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= undo_mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/rollback_union_find.sv @@
// Top level of the rollback union-find block: sequencer, config register, result register.
// Depends on ruf_pkg, ruf_parent_ram and ruf_undo_ram.
//
//   channel  direction  ports                                  item
//   req      in         req_valid, req_stall, req_data         ruf_pkg::req_type
//   rsp      out        rsp_valid, rsp_stall, rsp_data         ruf_pkg::rsp_type
//   csr      in         csr_wr_en, csr_wr_data                 num_nodes
//
// One item at a time. Each step of a parent chain walk is one read of the parent memory read
// port (chain length at most 10). Query: a find of node_a; join: two finds, then the
// merge steps MERGE_LO and MERGE_HI and the result; rollback: an undo read and a parent
// restore per popped entry, then a find of node_a.
// After reset a clearing pass writes every parent entry, with req_stall high.
// A finished result waits in the output register while the next item is taken in.
`default_nettype none

module rollback_union_find (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire ruf_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output ruf_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_wr_en,
   input  wire logic [ruf_pkg::COUNT_W-1:0]   csr_wr_data
);

   localparam int NW = ruf_pkg::NODE_W;
   localparam int EW = ruf_pkg::ENTRY_W;
   localparam int DW = ruf_pkg::DEPTH_W;
   localparam int CW = ruf_pkg::COUNT_W;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIND_A,
      ST_FIND_B,
      ST_MERGE_LO,
      ST_MERGE_HI,
      ST_POP_RD,
      ST_POP_WR,
      ST_RPT,
      ST_RPT_FIND,
      ST_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [NW-1:0]            clr_ff, clr_in;
   logic [NW-1:0]            a_ff, a_in;
   logic [NW-1:0]            b_ff, b_in;
   logic [DW-1:0]            tgt_ff, tgt_in;
   logic [DW-1:0]            depth_ff, depth_in;
   logic [NW-1:0]            cur_ff, cur_in;
   logic [NW-1:0]            ra_ff, ra_in;
   logic [EW-1:0]            va_ff, va_in;
   logic [NW-1:0]            rb_ff, rb_in;
   logic [EW-1:0]            vb_ff, vb_in;
   logic                     joined_ff, joined_in;
   logic [1:0]               err_ff, err_in;
   logic [NW-1:0]            root_ff, root_in;
   logic [CW-1:0]            size_ff, size_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   ruf_pkg::rsp_type         rsp_ff, rsp_in;
   logic [CW-1:0]            num_nodes_ff;

   logic [CW-1:0]            n_act;
   logic [NW-1:0]            merges;
   logic [CW-1:0]            comps;
   logic                     req_a_ok;
   logic                     req_b_ok;
   logic                     a_ok;

   ruf_pkg::par_wr_type      par_wr;
   ruf_pkg::par_rd_type      par_rd;
   logic [EW-1:0]            par_rd_data;
   ruf_pkg::undo_wr_type     undo_wr;
   ruf_pkg::undo_rd_type     undo_rd;
   ruf_pkg::undo_entry_type  undo_rd_data;

   ruf_parent_ram u_parent (
      .clock   (clock),
      .wr      (par_wr),
      .rd      (par_rd),
      .rd_data (par_rd_data)
   );

   ruf_undo_ram u_undo (
      .clock   (clock),
      .wr      (undo_wr),
      .rd      (undo_rd),
      .rd_data (undo_rd_data)
   );

   // Hold the node count register
   always_ff @(posedge clock) begin
      if (reset) begin
         num_nodes_ff <= CW'(ruf_pkg::MAX_NODES);
      end else if (csr_wr_en) begin
         num_nodes_ff <= csr_wr_data;
      end
   end

   // Saturate the node count to 1..MAX_NODES
   always_comb begin
      if (num_nodes_ff == '0) begin
         n_act = CW'(1);
      end else if (num_nodes_ff > CW'(ruf_pkg::MAX_NODES)) begin
         n_act = CW'(ruf_pkg::MAX_NODES);
      end else begin
         n_act = num_nodes_ff;
      end
   end

   assign req_a_ok = ({1'b0, req_data.node_a} < n_act);
   assign req_b_ok = ({1'b0, req_data.node_b} < n_act);
   assign a_ok     = ({1'b0, a_ff} < n_act);

   // Component count from merges on the stack, floored at zero
   assign merges = depth_ff[DW-1:1];
   assign comps  = (n_act > {1'b0, merges}) ? CW'(n_act - {1'b0, merges}) : '0;

   // Sequencer: next state, memory accesses, working registers
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      tgt_in       = tgt_ff;
      depth_in     = depth_ff;
      cur_in       = cur_ff;
      ra_in        = ra_ff;
      va_in        = va_ff;
      rb_in        = rb_ff;
      vb_in        = vb_ff;
      joined_in    = joined_ff;
      err_in       = err_ff;
      root_in      = root_ff;
      size_in      = size_ff;
      rsp_in       = rsp_ff;
      // drop the result once taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      par_wr       = '{en: 1'b0, addr: cur_ff, data: va_ff};
      par_rd       = '{en: 1'b0, addr: cur_ff};
      undo_wr      = '{en: 1'b0, addr: depth_ff, data: '{node: ra_ff, old: va_ff}};
      undo_rd      = '{en: 1'b0, addr: DW'(depth_ff - DW'(1))};

      unique case (state_ff)
         // Write every entry as a singleton set of size one
         ST_CLEAR: begin
            par_wr = '{en: 1'b1, addr: clr_ff, data: '1};
            clr_in = NW'(clr_ff + NW'(1));
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end

         // Take an item and decode the command
         ST_IDLE: begin
            if (req_valid) begin
               a_in      = req_data.node_a;
               b_in      = req_data.node_b;
               tgt_in    = req_data.target_depth;
               joined_in = 1'b0;
               err_in    = ruf_pkg::ERR_OK;
               unique case (req_data.command)
                  ruf_pkg::CMD_JOIN: begin
                     if (!req_a_ok || !req_b_ok) begin
                        err_in   = ruf_pkg::ERR_NODE;
                        state_in = ST_RPT;
                     end else begin
                        par_rd   = '{en: 1'b1, addr: req_data.node_a};
                        cur_in   = req_data.node_a;
                        state_in = ST_FIND_A;
                     end
                  end
                  ruf_pkg::CMD_ROLLBACK: begin
                     if (req_data.target_depth[0] || (req_data.target_depth > depth_ff)) begin
                        err_in   = ruf_pkg::ERR_TARGET;
                        state_in = ST_RPT;
                     end else if (req_data.target_depth == depth_ff) begin
                        state_in = ST_RPT;
                     end else begin
                        state_in = ST_POP_RD;
                     end
                  end
                  default: begin
                     // query, and the unused code acting as one
                     if (!req_a_ok) begin
                        err_in = ruf_pkg::ERR_NODE;
                     end
                     state_in = ST_RPT;
                  end
               endcase
            end
         end

         // Walk the chain of node_a; a negative word marks the root
         ST_FIND_A: begin
            if (par_rd_data[EW-1]) begin
               ra_in    = cur_ff;
               va_in    = par_rd_data;
               par_rd   = '{en: 1'b1, addr: b_ff};
               cur_in   = b_ff;
               state_in = ST_FIND_B;
            end else begin
               par_rd = '{en: 1'b1, addr: par_rd_data[NW-1:0]};
               cur_in = par_rd_data[NW-1:0];
            end
         end

         // Walk the chain of node_b, then order the roots by size
         ST_FIND_B: begin
            if (par_rd_data[EW-1]) begin
               if (cur_ff == ra_ff) begin
                  root_in  = ra_ff;
                  size_in  = CW'(-va_ff);
                  state_in = ST_DONE;
               end else begin
                  if ($signed(va_ff) > $signed(par_rd_data)) begin
                     // the set of node_b is larger: it keeps the root
                     ra_in = cur_ff;
                     va_in = par_rd_data;
                     rb_in = ra_ff;
                     vb_in = va_ff;
                  end else begin
                     rb_in = cur_ff;
                     vb_in = par_rd_data;
                  end
                  state_in = ST_MERGE_LO;
               end
            end else begin
               par_rd = '{en: 1'b1, addr: par_rd_data[NW-1:0]};
               cur_in = par_rd_data[NW-1:0];
            end
         end

         // Push the new root's old word and add the sizes
         ST_MERGE_LO: begin
            undo_wr  = '{en: 1'b1, addr: depth_ff, data: '{node: ra_ff, old: va_ff}};
            par_wr   = '{en: 1'b1, addr: ra_ff, data: EW'(va_ff + vb_ff)};
            state_in = ST_MERGE_HI;
         end

         // Push the other root's old word and link it under the new root
         ST_MERGE_HI: begin
            undo_wr   = '{en: 1'b1, addr: DW'(depth_ff + DW'(1)),
                          data: '{node: rb_ff, old: vb_ff}};
            par_wr    = '{en: 1'b1, addr: rb_ff, data: {1'b0, ra_ff}};
            depth_in  = DW'(depth_ff + DW'(2));
            joined_in = 1'b1;
            root_in   = ra_ff;
            size_in   = CW'(-(va_ff + vb_ff));
            state_in  = ST_DONE;
         end

         // Read the top of the undo stack
         ST_POP_RD: begin
            undo_rd  = '{en: 1'b1, addr: DW'(depth_ff - DW'(1))};
            depth_in = DW'(depth_ff - DW'(1));
            state_in = ST_POP_WR;
         end

         // Restore the popped word; the parent read of the report starts in ST_RPT
         ST_POP_WR: begin
            par_wr = '{en: 1'b1, addr: undo_rd_data.node, data: undo_rd_data.old};
            if (depth_ff == tgt_ff) begin
               state_in = ST_RPT;
            end else begin
               state_in = ST_POP_RD;
            end
         end

         // Start the find of node_a for the result
         ST_RPT: begin
            if (a_ok) begin
               par_rd   = '{en: 1'b1, addr: a_ff};
               cur_in   = a_ff;
               state_in = ST_RPT_FIND;
            end else begin
               root_in  = '0;
               size_in  = '0;
               state_in = ST_DONE;
            end
         end

         ST_RPT_FIND: begin
            if (par_rd_data[EW-1]) begin
               root_in  = cur_ff;
               size_in  = CW'(-par_rd_data);
               state_in = ST_DONE;
            end else begin
               par_rd = '{en: 1'b1, addr: par_rd_data[NW-1:0]};
               cur_in = par_rd_data[NW-1:0];
            end
         end

         // Load the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.joined     = joined_ff;
               rsp_in.root       = root_ff;
               rsp_in.set_size   = size_ff;
               rsp_in.undo_depth = depth_ff;
               rsp_in.components = comps;
               rsp_in.error      = err_ff;
               rsp_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff      <= a_in;
      b_ff      <= b_in;
      tgt_ff    <= tgt_in;
      cur_ff    <= cur_in;
      ra_ff     <= ra_in;
      va_ff     <= va_in;
      rb_ff     <= rb_in;
      vb_ff     <= vb_in;
      joined_ff <= joined_in;
      err_ff    <= err_in;
      root_ff   <= root_in;
      size_ff   <= size_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // The stack holds whole pairs between items
   a_depth_even: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !depth_ff[0])
      else $error("undo depth odd while idle");

   // A merge grows the stack by one pair
   a_merge_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE_HI) |=> (depth_ff == DW'($past(depth_ff) + DW'(2))))
      else $error("merge did not push two entries");

   // Pops never go below the rollback target
   a_pop_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP_RD) |-> (depth_ff > tgt_ff))
      else $error("pop below rollback target");

   // A merged join never carries an error
   a_join_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.joined) |-> (rsp_ff.error == ruf_pkg::ERR_OK))
      else $error("joined result with error");
`endif

endmodule

`default_nettype wire
